@@ design/jbnv_pkg.sv @@
package jbnv_pkg;

	// Byte codes the classifier looks for.
	localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
	localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
	localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
	localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
	localparam logic [7:0] CH_BACKSLASH    = 8'h5C;
	localparam logic [7:0] CH_QUOTE        = 8'h22;
	localparam logic [7:0] CH_SPACE       = 8'h20;
	localparam logic [7:0] CH_TAB         = 8'h09;
	localparam logic [7:0] CH_CR          = 8'h0D;

	typedef enum logic [2:0] {
		CL_OTHER,
		CL_BACKSLASH,
		CL_QUOTE,
		CL_OPEN_CURLY,
		CL_OPEN_SQUARE,
		CL_CLOSE_CURLY,
		CL_CLOSE_SQUARE
	} byte_class_t;

	typedef enum logic [1:0] {
		LK_NONE,
		LK_CURLY,
		LK_SQUARE,
		LK_OTHER
	} lead_kind_t;

	typedef enum logic [2:0] {
		ST_OBJECT,
		ST_ARRAY,
		ST_EXTRA_CLOSE,
		ST_EXPECT_SQUARE,
		ST_EXPECT_CURLY,
		ST_UNCLOSED,
		ST_NO_CONTAINER,
		ST_OVERFLOW
	} status_t;

	// One classified byte as it travels from the front to the back.
	typedef struct packed {
		byte_class_t cls;
		lead_kind_t  lead;
		logic        last;
	} item_t;

	// Stack commands from the back, and stack flags returned to it.
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
		logic kind;
	} stack_cmd_t;

	typedef struct packed {
		logic empty;
		logic single;
		logic full;
		logic top;
	} stack_stat_t;

endpackage

@@ design/jbnv_queue.sv @@
module jbnv_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			data_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ design/jbnv_front.sv @@
module jbnv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          text_byte,
	input  logic                is_last,
	output jbnv_pkg::item_t     item
);

	jbnv_pkg::lead_kind_t lead_q;
	jbnv_pkg::lead_kind_t lead_now;
	jbnv_pkg::byte_class_t cls;
	logic                 blank;

	assign blank = (text_byte == jbnv_pkg::CH_SPACE) ||
		((text_byte >= jbnv_pkg::CH_TAB) && (text_byte <= jbnv_pkg::CH_CR));

	always_comb begin
		case (text_byte)
			jbnv_pkg::CH_BACKSLASH:    cls = jbnv_pkg::CL_BACKSLASH;
			jbnv_pkg::CH_QUOTE:        cls = jbnv_pkg::CL_QUOTE;
			jbnv_pkg::CH_OPEN_CURLY:   cls = jbnv_pkg::CL_OPEN_CURLY;
			jbnv_pkg::CH_OPEN_SQUARE:  cls = jbnv_pkg::CL_OPEN_SQUARE;
			jbnv_pkg::CH_CLOSE_CURLY:  cls = jbnv_pkg::CL_CLOSE_CURLY;
			jbnv_pkg::CH_CLOSE_SQUARE: cls = jbnv_pkg::CL_CLOSE_SQUARE;
			default:                   cls = jbnv_pkg::CL_OTHER;
		endcase
	end

	// The first byte outside the whitespace set fixes the leading kind.
	always_comb begin
		lead_now = lead_q;
		if (lead_q == jbnv_pkg::LK_NONE && !blank) begin
			case (cls)
				jbnv_pkg::CL_OPEN_CURLY:  lead_now = jbnv_pkg::LK_CURLY;
				jbnv_pkg::CL_OPEN_SQUARE: lead_now = jbnv_pkg::LK_SQUARE;
				default:                  lead_now = jbnv_pkg::LK_OTHER;
			endcase
		end
	end

	assign item.cls  = cls;
	assign item.lead = lead_now;
	assign item.last = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= jbnv_pkg::LK_NONE;
		end else if (accept) begin
			lead_q <= is_last ? jbnv_pkg::LK_NONE : lead_now;
		end
	end

endmodule

@@ design/jbnv_stack.sv @@
module jbnv_stack #(
	parameter int MAX_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  jbnv_pkg::stack_cmd_t  cmd,
	output jbnv_pkg::stack_stat_t stat
);

	localparam int AW = $clog2(MAX_DEPTH);
	localparam int CW = $clog2(MAX_DEPTH + 1);

	logic          kinds_q [MAX_DEPTH];
	logic [CW-1:0] count_q;
	logic [CW-1:0] below_top;
	logic          top_q;
	logic          rd_q;
	logic          top_sel_q;

	// The top level lives in a register after a push; after a pop the new top
	// is the entry below, read from the memory on the same edge.
	assign below_top   = count_q - CW'(2);
	assign stat.empty  = (count_q == '0);
	assign stat.single = (count_q == CW'(1));
	assign stat.full   = (count_q == CW'(MAX_DEPTH));
	assign stat.top    = top_sel_q ? rd_q : top_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			kinds_q[count_q[AW-1:0]] <= cmd.kind;
		end
		if (cmd.pop) begin
			rd_q <= kinds_q[below_top[AW-1:0]];
		end
		if (cmd.push) begin
			top_q <= cmd.kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			top_sel_q <= 1'b0;
		end else if (cmd.clear) begin
			count_q   <= '0;
			top_sel_q <= 1'b0;
		end else if (cmd.push) begin
			count_q   <= count_q + 1'b1;
			top_sel_q <= 1'b0;
		end else if (cmd.pop) begin
			count_q   <= count_q - 1'b1;
			top_sel_q <= 1'b1;
		end
	end

	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.pop))
		else $error("stack push and pop in the same cycle");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (count_q != '0))
		else $error("stack pop while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (count_q != CW'(MAX_DEPTH)))
		else $error("stack push while full");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (count_q == '0))
		else $error("stack not empty after clear");

endmodule

@@ design/jbnv_back.sv @@
module jbnv_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  jbnv_pkg::item_t       item,
	output logic                  item_take,
	output jbnv_pkg::stack_cmd_t  cmd,
	input  jbnv_pkg::stack_stat_t stat,
	output logic                  res_push,
	output jbnv_pkg::status_t     res_status,
	input  logic                  res_full
);

	logic              esc_q;
	logic              str_q;
	logic              errv_q;
	jbnv_pkg::status_t err_q;
	logic              esc_n;
	logic              str_n;
	logic              errv_n;
	jbnv_pkg::status_t err_n;
	logic              open_after;

	// A last beat needs a free result slot; every other beat goes straight on.
	assign item_take = item_valid && (!item.last || !res_full);
	assign res_push  = item_take && item.last;

	always_comb begin
		esc_n  = esc_q;
		str_n  = str_q;
		errv_n = errv_q;
		err_n  = err_q;
		cmd    = '0;
		if (item_take && !errv_q) begin
			if (item.cls == jbnv_pkg::CL_BACKSLASH && !esc_q) begin
				esc_n = 1'b1;
			end else begin
				esc_n = 1'b0;
				case (item.cls)
					jbnv_pkg::CL_QUOTE: begin
						if (!esc_q) begin
							str_n = !str_q;
						end
					end
					jbnv_pkg::CL_OPEN_CURLY, jbnv_pkg::CL_OPEN_SQUARE: begin
						if (!str_q) begin
							if (stat.full) begin
								errv_n = 1'b1;
								err_n  = jbnv_pkg::ST_OVERFLOW;
							end else begin
								cmd.push = 1'b1;
								cmd.kind = (item.cls == jbnv_pkg::CL_OPEN_SQUARE);
							end
						end
					end
					jbnv_pkg::CL_CLOSE_CURLY: begin
						if (!str_q) begin
							if (stat.empty) begin
								errv_n = 1'b1;
								err_n  = jbnv_pkg::ST_EXTRA_CLOSE;
							end else if (stat.top) begin
								errv_n = 1'b1;
								err_n  = jbnv_pkg::ST_EXPECT_SQUARE;
							end else begin
								cmd.pop = 1'b1;
							end
						end
					end
					jbnv_pkg::CL_CLOSE_SQUARE: begin
						if (!str_q) begin
							if (stat.empty) begin
								errv_n = 1'b1;
								err_n  = jbnv_pkg::ST_EXTRA_CLOSE;
							end else if (!stat.top) begin
								errv_n = 1'b1;
								err_n  = jbnv_pkg::ST_EXPECT_CURLY;
							end else begin
								cmd.pop = 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
		if (res_push) begin
			cmd.clear = 1'b1;
		end
	end

	assign open_after = cmd.push || (!stat.empty && !(cmd.pop && stat.single));

	always_comb begin
		if (errv_n) begin
			res_status = err_n;
		end else if (open_after) begin
			res_status = jbnv_pkg::ST_UNCLOSED;
		end else begin
			case (item.lead)
				jbnv_pkg::LK_CURLY:  res_status = jbnv_pkg::ST_OBJECT;
				jbnv_pkg::LK_SQUARE: res_status = jbnv_pkg::ST_ARRAY;
				default:             res_status = jbnv_pkg::ST_NO_CONTAINER;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= 1'b0;
			str_q  <= 1'b0;
			errv_q <= 1'b0;
			err_q  <= jbnv_pkg::ST_OBJECT;
		end else if (res_push) begin
			esc_q  <= 1'b0;
			str_q  <= 1'b0;
			errv_q <= 1'b0;
			err_q  <= jbnv_pkg::ST_OBJECT;
		end else begin
			esc_q  <= esc_n;
			str_q  <= str_n;
			errv_q <= errv_n;
			err_q  <= err_n;
		end
	end

	a_doc_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (!esc_q && !str_q && !errv_q))
		else $error("tracking state not cleared after a document");

	a_no_stack_after_err: assert property (@(posedge clk) disable iff (!arst_n)
		errv_q |-> (!cmd.push && !cmd.pop))
		else $error("stack moved after a sticky error");

endmodule

@@ design/json_bracket_nesting_validator.sv @@
// Streaming bracket checker for JSON text, one byte per beat.
// Input channel: drive text_byte and is_last with push; a beat is taken at a
// rising edge with push high and full low. Mark the final byte of each
// document with is_last.
// Result channel: one status beat per document, produced by the byte marked
// last. While empty is low the oldest status is on the status port; it is
// taken at a rising edge with pop high and empty low.
// Status codes: object, array, extra close, expected ], expected }, unclosed,
// no container at top level, and nesting deeper than MAX_DEPTH.
// Throughput is one byte per cycle while full is low: the front classifies
// a byte and writes a two-entry queue, and the back consumes one queued
// byte per cycle unless a last byte waits for a result slot, using the
// stack top held in a register or read from the stack memory on the edge
// of the pop that exposes it; statuses are registered in the output queue.
// If the receiver stalls, results collect in a two-entry output queue; a
// last byte then waits in the middle queue, and full rises once that queue
// fills, while ordinary bytes keep flowing as long as the middle queue has
// room. After the last byte of a document the tracking state returns to
// its reset values. Asynchronous reset empties all queues and clears all
// tracking state; the stack memory itself is not cleared.
module json_bracket_nesting_validator #(
	parameter int MAX_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] text_byte,
	input  logic       is_last,
	output logic       empty,
	input  logic       pop,
	output logic [2:0] status
);

	localparam int ITEM_W   = $bits(jbnv_pkg::item_t);
	localparam int STATUS_W = $bits(jbnv_pkg::status_t);

	jbnv_pkg::item_t       front_item;
	logic [ITEM_W-1:0]     mid_rdata;
	jbnv_pkg::item_t       back_item;
	logic                  mid_empty;
	logic                  item_take;
	jbnv_pkg::stack_cmd_t  stack_cmd;
	jbnv_pkg::stack_stat_t stack_stat;
	logic                  res_push;
	jbnv_pkg::status_t     res_status;
	logic                  res_full;
	logic [STATUS_W-1:0]   out_rdata;
	logic                  accept;

	assign accept    = push && !full;
	assign back_item = jbnv_pkg::item_t'(mid_rdata);
	assign status    = out_rdata;

	jbnv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text_byte (text_byte),
		.is_last   (is_last),
		.item      (front_item)
	);

	// Classified bytes wait here until the back can take them.
	jbnv_queue #(
		.WIDTH (ITEM_W),
		.DEPTH (2)
	) u_mid_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_item),
		.full    (full),
		.rd_en   (item_take),
		.rd_data (mid_rdata),
		.empty   (mid_empty)
	);

	jbnv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!mid_empty),
		.item       (back_item),
		.item_take  (item_take),
		.cmd        (stack_cmd),
		.stat       (stack_stat),
		.res_push   (res_push),
		.res_status (res_status),
		.res_full   (res_full)
	);

	jbnv_stack #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (stack_cmd),
		.stat   (stack_stat)
	);

	// Finished statuses wait here for the receiver.
	jbnv_queue #(
		.WIDTH (STATUS_W),
		.DEPTH (2)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_status),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (out_rdata),
		.empty   (empty)
	);

endmodule

@@ tb/testbench.sv @@
module testbench;

	localparam int NEST_LIMIT = 64;
	// Cycles without a single accepted beat on either side before the run is
	// declared hung.
	localparam int STALL_LIMIT = 2000;
	// Minimum number of queued text bytes, directed ones included, before the random part may stop.
	localparam int TEXT_BUDGET = 560;

	// Whitespace bytes that the package does not name.
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;

	typedef struct {
		logic [7:0] b;
		logic       last;
	} text_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] text_byte = 8'h00;
	logic       is_last = 1'b0;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic [2:0] status;

	json_bracket_nesting_validator #(
		.MAX_DEPTH(NEST_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.text_byte(text_byte),
		.is_last(is_last),
		.empty(empty),
		.pop(pop),
		.status(status)
	);

	always #5 clk = ~clk;

	// Text bytes waiting to be sent, and the document being assembled by the
	// stimulus generator before it is appended with its last-byte mark.
	text_beat_t byte_queue[$];
	logic [7:0] doc[$];

	// Statuses that the documents already sent must produce, oldest first.
	jbnv_pkg::status_t status_due[$];

	// Our own copy of the checker's tracking state.
	bit                   esc_armed;
	bit                   str_open;
	bit [NEST_LIMIT-1:0]  kind_stack;
	int                   nest_depth;
	bit                   sticky_set;
	jbnv_pkg::status_t    sticky_err;
	jbnv_pkg::lead_kind_t lead;

	int errors = 0;
	int beats_in = 0;
	int quiet_cycles = 0;
	bit in_taken = 1'b0;
	jbnv_pkg::status_t want;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	task automatic clear_nesting();
		esc_armed = 1'b0;
		str_open = 1'b0;
		nest_depth = 0;
		sticky_set = 1'b0;
		sticky_err = jbnv_pkg::ST_OBJECT;
		lead = jbnv_pkg::LK_NONE;
	endtask

	// Advances the tracking state by one text byte. On the last byte of a
	// document the status it must produce is queued and the state clears.
	task automatic nest_predict(input logic [7:0] b, input logic last);
		jbnv_pkg::status_t st;
		bit blank;
		bit is_open;
		bit is_close;
		blank = (b == jbnv_pkg::CH_SPACE) ||
			(b >= jbnv_pkg::CH_TAB && b <= jbnv_pkg::CH_CR);
		is_open = (b == jbnv_pkg::CH_OPEN_CURLY) || (b == jbnv_pkg::CH_OPEN_SQUARE);
		is_close = (b == jbnv_pkg::CH_CLOSE_CURLY) || (b == jbnv_pkg::CH_CLOSE_SQUARE);
		if (lead == jbnv_pkg::LK_NONE && !blank) begin
			if (b == jbnv_pkg::CH_OPEN_CURLY)
				lead = jbnv_pkg::LK_CURLY;
			else if (b == jbnv_pkg::CH_OPEN_SQUARE)
				lead = jbnv_pkg::LK_SQUARE;
			else
				lead = jbnv_pkg::LK_OTHER;
		end
		// Once an error is latched nothing else is tracked.
		if (!sticky_set) begin
			if (b == jbnv_pkg::CH_BACKSLASH && !esc_armed) begin
				esc_armed = 1'b1;
			end else begin
				if (b == jbnv_pkg::CH_QUOTE && !esc_armed) begin
					str_open = !str_open;
				end else if (is_open && !str_open) begin
					if (nest_depth >= NEST_LIMIT) begin
						sticky_set = 1'b1;
						sticky_err = jbnv_pkg::ST_OVERFLOW;
					end else begin
						kind_stack[nest_depth] = (b == jbnv_pkg::CH_OPEN_SQUARE);
						nest_depth++;
					end
				end else if (is_close && !str_open) begin
					if (nest_depth == 0) begin
						sticky_set = 1'b1;
						sticky_err = jbnv_pkg::ST_EXTRA_CLOSE;
					end else if (b == jbnv_pkg::CH_CLOSE_CURLY &&
						kind_stack[nest_depth-1]) begin
						sticky_set = 1'b1;
						sticky_err = jbnv_pkg::ST_EXPECT_SQUARE;
					end else if (b == jbnv_pkg::CH_CLOSE_SQUARE &&
						!kind_stack[nest_depth-1]) begin
						sticky_set = 1'b1;
						sticky_err = jbnv_pkg::ST_EXPECT_CURLY;
					end else begin
						nest_depth--;
					end
				end
				// An escape outside a string never hides a bracket; it is
				// simply consumed by whatever byte follows it.
				esc_armed = 1'b0;
			end
		end
		if (last) begin
			if (sticky_set)
				st = sticky_err;
			else if (nest_depth != 0)
				st = jbnv_pkg::ST_UNCLOSED;
			else if (lead == jbnv_pkg::LK_CURLY)
				st = jbnv_pkg::ST_OBJECT;
			else if (lead == jbnv_pkg::LK_SQUARE)
				st = jbnv_pkg::ST_ARRAY;
			else
				st = jbnv_pkg::ST_NO_CONTAINER;
			status_due.insert(status_due.size(), st);
			clear_nesting();
		end
	endtask

	// Moves the assembled document onto the send queue, marking its final
	// byte as the last one.
	task automatic flush_doc();
		text_beat_t t;
		foreach (doc[i]) begin
			t.b = doc[i];
			t.last = (i == doc.size() - 1);
			byte_queue.insert(byte_queue.size(), t);
		end
		doc.delete();
	endtask

	// Appends one byte to the document under construction.
	task automatic put_byte(input logic [7:0] b);
		doc.insert(doc.size(), b);
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 5))
			0: return jbnv_pkg::CH_SPACE;
			1: return jbnv_pkg::CH_TAB;
			2: return CH_LF;
			3: return CH_VT;
			4: return CH_FF;
			default: return jbnv_pkg::CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] pick_bracket();
		case ($urandom_range(0, 3))
			0: return jbnv_pkg::CH_OPEN_CURLY;
			1: return jbnv_pkg::CH_OPEN_SQUARE;
			2: return jbnv_pkg::CH_CLOSE_CURLY;
			default: return jbnv_pkg::CH_CLOSE_SQUARE;
		endcase
	endfunction

	function automatic logic [7:0] close_of(input bit square);
		return square ? jbnv_pkg::CH_CLOSE_SQUARE : jbnv_pkg::CH_CLOSE_CURLY;
	endfunction

	function automatic logic [7:0] open_of(input bit square);
		return square ? jbnv_pkg::CH_OPEN_SQUARE : jbnv_pkg::CH_OPEN_CURLY;
	endfunction

	// A quoted string whose body carries brackets, escaped quotes and
	// backslashes, and arbitrary bytes. Now and then the closing quote is
	// left off so that the string runs on into the rest of the text.
	task automatic gen_string();
		logic [7:0] c;
		put_byte(jbnv_pkg::CH_QUOTE);
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(0, 4))
				0: put_byte(pick_bracket());
				1: begin
					put_byte(jbnv_pkg::CH_BACKSLASH);
					case ($urandom_range(0, 2))
						0: put_byte(jbnv_pkg::CH_QUOTE);
						1: put_byte(jbnv_pkg::CH_BACKSLASH);
						default: put_byte(8'($urandom_range(0, 255)));
					endcase
				end
				default: begin
					c = 8'($urandom_range(0, 255));
					if (c == jbnv_pkg::CH_QUOTE || c == jbnv_pkg::CH_BACKSLASH)
						c = "x";
					put_byte(c);
				end
			endcase
		end
		if ($urandom_range(0, 9) != 0)
			put_byte(jbnv_pkg::CH_QUOTE);
	endtask

	// A JSON-like document with random content. About one in five carries a
	// flaw: a close of the wrong kind, one close too many, a container left
	// open, or a random printable byte ahead of the top-level container.
	task automatic gen_doc();
		bit kinds[$];
		int flaw;
		bit k;
		flaw = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
		repeat ($urandom_range(0, 2))
			put_byte(pick_blank());
		if (flaw == 4)
			put_byte(8'($urandom_range(8'h30, 8'h7A)));
		k = $urandom_range(0, 1);
		kinds.insert(kinds.size(), k);
		put_byte(open_of(k));
		repeat ($urandom_range(1, 9)) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					if (kinds.size() < 8) begin
						k = $urandom_range(0, 1);
						kinds.insert(kinds.size(), k);
						put_byte(open_of(k));
					end
				end
				3, 4: begin
					if (kinds.size() > 1) begin
						put_byte(close_of(kinds[kinds.size()-1]));
						kinds.delete(kinds.size()-1);
					end
				end
				5, 6: gen_string();
				7: put_byte(pick_blank());
				8: put_byte(8'($urandom_range(0, 255)));
				default: begin
					// A backslash outside a string still lets the bracket count.
					k = $urandom_range(0, 1);
					kinds.insert(kinds.size(), k);
					put_byte(jbnv_pkg::CH_BACKSLASH);
					put_byte(open_of(k));
				end
			endcase
		end
		if (flaw == 1)
			put_byte(close_of(!kinds[kinds.size()-1]));
		if (flaw == 3)
			void'(kinds.pop_front());
		while (kinds.size() != 0) begin
			put_byte(close_of(kinds[kinds.size()-1]));
			kinds.delete(kinds.size()-1);
		end
		if (flaw == 2)
			put_byte(pick_bracket() == jbnv_pkg::CH_CLOSE_CURLY ?
				jbnv_pkg::CH_CLOSE_CURLY : jbnv_pkg::CH_CLOSE_SQUARE);
		if ($urandom_range(0, 2) == 0)
			put_byte(pick_blank());
		// A document that ended up empty still needs a byte to carry the mark.
		if (doc.size() == 0)
			put_byte(jbnv_pkg::CH_SPACE);
		flush_doc();
	endtask

	// Short runs of loose bytes, heavy in the bytes the checker reacts to.
	task automatic gen_noise();
		repeat ($urandom_range(1, 10)) begin
			case ($urandom_range(0, 3))
				0: put_byte(pick_bracket());
				1: put_byte($urandom_range(0, 1) ?
					jbnv_pkg::CH_QUOTE : jbnv_pkg::CH_BACKSLASH);
				default: put_byte(8'($urandom_range(0, 255)));
			endcase
		end
		flush_doc();
	endtask

	// Nesting of a chosen depth, closed again when asked to. A depth above
	// the limit must latch the overflow error.
	task automatic gen_deep(input int levels, input bit close_all);
		bit kinds[$];
		bit k;
		repeat (levels) begin
			k = $urandom_range(0, 1);
			kinds.insert(kinds.size(), k);
			put_byte(open_of(k));
		end
		while (close_all && kinds.size() != 0) begin
			put_byte(close_of(kinds[kinds.size()-1]));
			kinds.delete(kinds.size()-1);
		end
		flush_doc();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	// Stimulus. The directed documents come first: each closing form of the
	// status, brackets hidden inside a string, an escaped quote, an escaped
	// bracket outside a string, leading whitespace, and the byte extremes.
	// Random documents follow, with one nesting exactly at the limit and one
	// just past it placed among them.
	initial begin
		int docs;
		clear_nesting();
		add_text("{}");
		flush_doc();
		put_byte(jbnv_pkg::CH_TAB);
		add_text("[]");
		flush_doc();
		add_text("]");
		flush_doc();
		add_text("[}");
		flush_doc();
		add_text("{]");
		flush_doc();
		add_text("{\"}\"");
		flush_doc();
		add_text("\\[]");
		flush_doc();
		add_text("[\"\\\"\"]");
		flush_doc();
		put_byte(8'h00);
		put_byte(8'hFF);
		flush_doc();

		docs = 0;
		while (byte_queue.size() < TEXT_BUDGET || docs < 40) begin
			if (docs == 8)
				gen_deep(NEST_LIMIT, 1'b1);
			else if (docs == 20)
				gen_deep(NEST_LIMIT + 1, 1'b0);
			else if ($urandom_range(0, 9) == 0)
				gen_noise();
			else
				gen_doc();
			docs++;
		end

		// Reset is released on a falling edge, so the driver first sees it high
		// at the next falling edge.
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		while (byte_queue.size() != 0 || status_due.size() != 0)
			@(posedge clk);
		// The wait that follows catches any status beat that should not exist.
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// For a stretch of the text both sides run flat out; elsewhere each side
	// sits out about a quarter of its cycles at random.
	function automatic bit take_turn();
		if (beats_in >= 200 && beats_in < 330)
			return 1'b1;
		return $urandom_range(0, 99) >= 26;
	endfunction

	// Driver. Works on the falling edge: drops the byte the last rising edge
	// took, then offers the next one or idles.
	always @(negedge clk) begin
		if (in_taken)
			byte_queue.delete(0);
		if (arst_n && byte_queue.size() != 0 && take_turn()) begin
			push <= 1'b1;
			text_byte <= byte_queue[0].b;
			is_last <= byte_queue[0].last;
		end else begin
			push <= 1'b0;
		end
		pop <= arst_n && take_turn();
	end

	// Monitor. Samples both channels on the rising edge, predicts on every
	// accepted text beat and checks every accepted status beat. It also acts
	// as the watchdog for a run that stops moving.
	always @(posedge clk) begin
		in_taken = 1'b0;
		if (arst_n) begin
			if (push && !full) begin
				in_taken = 1'b1;
				beats_in++;
				nest_predict(text_byte, is_last);
			end
			if (pop && !empty) begin
				if (status_due.size() == 0) begin
					report_mismatch($sformatf("status %0d with no document pending", status));
				end else begin
					want = status_due.pop_front();
					if (status !== want)
						report_mismatch($sformatf("status %0d, expected %0d (%s)",
							status, want, want.name()));
				end
			end
			if (in_taken || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat for %0d cycles", STALL_LIMIT);
				$display("testbench: errors");
				$finish;
			end
		end
	end

endmodule
